FILE: sv/trdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdp_pkg
// Shared types and constants for the touch report decode and phase unit.
// ----------------------------------------------------------------------------
package trdp_pkg;

    // Report formats selected by the controller type register.
    localparam logic [1:0] CTRL_NONE  = 2'd0;
    localparam logic [1:0] CTRL_CSUM  = 2'd1;
    localparam logic [1:0] CTRL_EVENT = 2'd2;
    localparam logic [1:0] CTRL_RSVD  = 2'd3;

    localparam logic [7:0]  HDR_BYTE   = 8'hff;
    localparam logic [15:0] CSUM_SEED  = 16'h0055;
    localparam logic [3:0]  EVT_TOUCH  = 4'h8;
    localparam logic [7:0]  ONE_FINGER = 8'd1;

    localparam int unsigned XW = 8;   // stored X width
    localparam int unsigned YW = 10;  // stored Y width
    localparam int unsigned RW = 12;  // raw coordinate width in a report

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_MOVE = 2'd2,
        EV_UP   = 2'd3
    } t_event;

    // Decoded sample handed from the decoder to the phase tracker.
    typedef struct packed {
        logic          valid;
        logic          touch;
        logic [RW-1:0] x;
        logic [RW-1:0] y;
    } t_sample;

    // One result item.
    typedef struct packed {
        logic          sample_valid;
        logic          ack_needed;
        t_event        event_res;
        logic          touching;
        logic [XW-1:0] pos_x;
        logic [YW-1:0] pos_y;
        logic [XW-1:0] latest_move_x;
        logic [YW-1:0] latest_move_y;
        logic          move_pending;
    } t_result;

endpackage

FILE: sv/trdp_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdp_decoder
// Decodes one registered report in the selected format and range-checks it.
// ----------------------------------------------------------------------------
module trdp_decoder #(
    parameter int PANEL_WIDTH  = 180,
    parameter int PANEL_HEIGHT = 640
) (
    input  logic [1:0]       i_ctrl,
    input  logic             i_read_ok,
    input  logic [7:0]       i_byte0,
    input  logic [7:0]       i_byte1,
    input  logic [7:0]       i_byte2,
    input  logic [7:0]       i_byte3,
    input  logic [7:0]       i_byte4,
    input  logic [7:0]       i_byte5,
    input  logic [7:0]       i_byte6,
    input  logic [7:0]       i_byte7,
    input  logic [7:0]       i_byte8,
    output trdp_pkg::t_sample o_sample
);

    localparam logic [trdp_pkg::RW-1:0] PW = trdp_pkg::RW'(PANEL_WIDTH);
    localparam logic [trdp_pkg::RW-1:0] PH = trdp_pkg::RW'(PANEL_HEIGHT);

    logic [15:0]             w_sum;
    logic [15:0]             w_expect;
    logic [3:0]              w_fingers;
    logic [trdp_pkg::RW-1:0] w_x1;
    logic [trdp_pkg::RW-1:0] w_y1;
    logic [trdp_pkg::RW-1:0] w_x2;
    logic [trdp_pkg::RW-1:0] w_raw2;

    assign w_sum = trdp_pkg::CSUM_SEED + {8'd0, i_byte4} + {8'd0, i_byte5}
                 + {8'd0, i_byte6} + {8'd0, i_byte7} + {8'd0, i_byte8};
    assign w_expect  = {i_byte1, i_byte0};
    assign w_fingers = i_byte3[3:0];
    assign w_x1      = {i_byte7[3:0], i_byte4};
    assign w_y1      = {i_byte7[7:4], i_byte5};
    assign w_x2      = {i_byte4[3:0], i_byte5};
    assign w_raw2    = {i_byte2[3:0], i_byte3};

    always_comb begin
        o_sample = '0;
        if (i_read_ok) begin
            case (i_ctrl)
                trdp_pkg::CTRL_CSUM: begin
                    if (i_byte2 == trdp_pkg::HDR_BYTE && w_fingers <= 4'd1) begin
                        if (w_fingers == 4'd0 || i_byte8[7:4] == 4'd0) begin
                            o_sample.valid = 1'b1;
                        end else if (w_sum == w_expect) begin
                            o_sample.touch = 1'b1;
                            o_sample.x     = w_x1;
                            o_sample.y     = w_y1;
                            o_sample.valid = (w_x1 < PW) && (w_y1 < PH);
                        end
                    end
                end
                trdp_pkg::CTRL_EVENT: begin
                    if (i_byte1 != trdp_pkg::ONE_FINGER
                        || i_byte2[7:4] != trdp_pkg::EVT_TOUCH) begin
                        o_sample.valid = 1'b1;
                    end else begin
                        // Y is mirrored; it lands inside the panel only for
                        // a raw value from one up to the panel height.
                        o_sample.touch = 1'b1;
                        o_sample.x     = w_x2;
                        o_sample.y     = PH - w_raw2;
                        o_sample.valid = (w_x2 < PW) && (w_raw2 != '0)
                                         && (w_raw2 <= PH);
                    end
                end
                default: begin
                    o_sample = '0;
                end
            endcase
        end
    end

endmodule

FILE: sv/trdp_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdp_tracker
// Down/move/up phase tracker with move coalescing until acknowledged.
// ----------------------------------------------------------------------------
module trdp_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_move_ack,
    input  trdp_pkg::t_sample i_sample,
    output trdp_pkg::t_event  o_event,
    output logic              o_active,
    output logic [trdp_pkg::XW-1:0] o_cur_x,
    output logic [trdp_pkg::YW-1:0] o_cur_y,
    output logic [trdp_pkg::XW-1:0] o_lat_x,
    output logic [trdp_pkg::YW-1:0] o_lat_y,
    output logic              o_pend
);

    logic                    r_active, n_active;
    logic [trdp_pkg::XW-1:0] r_cur_x, n_cur_x;
    logic [trdp_pkg::YW-1:0] r_cur_y, n_cur_y;
    logic [trdp_pkg::XW-1:0] r_lat_x, n_lat_x;
    logic [trdp_pkg::YW-1:0] r_lat_y, n_lat_y;
    logic                    r_pend, n_pend;
    trdp_pkg::t_event        w_event;
    logic [trdp_pkg::XW-1:0] w_nx;
    logic [trdp_pkg::YW-1:0] w_ny;

    always_comb begin
        n_active = r_active;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_lat_x  = r_lat_x;
        n_lat_y  = r_lat_y;
        n_pend   = r_pend && !i_move_ack;
        w_event  = trdp_pkg::EV_NONE;
        w_nx     = i_sample.touch ? i_sample.x[trdp_pkg::XW-1:0] : r_cur_x;
        w_ny     = i_sample.touch ? i_sample.y[trdp_pkg::YW-1:0] : r_cur_y;
        if (i_sample.valid) begin
            if (i_sample.touch && !r_active) begin
                n_lat_x = w_nx;
                n_lat_y = w_ny;
                w_event = trdp_pkg::EV_DOWN;
            end else if (i_sample.touch && (w_nx != r_cur_x || w_ny != r_cur_y)) begin
                n_lat_x = w_nx;
                n_lat_y = w_ny;
                // Further moves only refresh the latest position until the
                // host acknowledges the pending one.
                if (!n_pend) begin
                    n_pend  = 1'b1;
                    w_event = trdp_pkg::EV_MOVE;
                end
            end else if (!i_sample.touch && r_active) begin
                w_event = trdp_pkg::EV_UP;
            end
            n_cur_x  = w_nx;
            n_cur_y  = w_ny;
            n_active = i_sample.touch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_lat_x  <= '0;
            r_lat_y  <= '0;
            r_pend   <= 1'b0;
        end else if (i_take) begin
            r_active <= n_active;
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_lat_x  <= n_lat_x;
            r_lat_y  <= n_lat_y;
            r_pend   <= n_pend;
        end
    end

    assign o_event  = w_event;
    assign o_active = n_active;
    assign o_cur_x  = n_cur_x;
    assign o_cur_y  = n_cur_y;
    assign o_lat_x  = n_lat_x;
    assign o_lat_y  = n_lat_y;
    assign o_pend   = n_pend;

endmodule

FILE: sv/touch_report_decode_and_phase_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_report_decode_and_phase_unit
// Decodes finished touch reports and tracks the down/move/up phase.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one report item: read_ok, the host
//   move acknowledge and bytes 0..8. Output channel o_valid/i_ready carries
//   one result item per report. The report format comes from the controller
//   type register, written through i_cfg_we/i_cfg_wdata; the user must write it
//   only while the block is idle, which the block itself does not enforce.
//   An accepted item lands in an input register; from there it is decoded,
//   the phase state is updated and the result is loaded into the output
//   register once that register is free or being emptied. One item is taken
//   per cycle as long as the receiver keeps up. The depth is set by the
//   input register and the output register around the decode.
//   When i_ready is low the result holds; the input register still takes
//   one more item, after which o_ready drops until the result is taken.
//   Synchronous reset clears both stages, the phase state (not touching,
//   positions zero, no pending move) and selects no controller format.
// ----------------------------------------------------------------------------
module touch_report_decode_and_phase_unit #(
    parameter int PANEL_WIDTH  = 180,
    parameter int PANEL_HEIGHT = 640
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_read_ok,
    input  logic        i_move_acknowledged,
    input  logic [7:0]  i_byte0,
    input  logic [7:0]  i_byte1,
    input  logic [7:0]  i_byte2,
    input  logic [7:0]  i_byte3,
    input  logic [7:0]  i_byte4,
    input  logic [7:0]  i_byte5,
    input  logic [7:0]  i_byte6,
    input  logic [7:0]  i_byte7,
    input  logic [7:0]  i_byte8,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_sample_valid,
    output logic        o_ack_needed,
    output logic [1:0]  o_event_res,
    output logic        o_touching,
    output logic [7:0]  o_pos_x,
    output logic [9:0]  o_pos_y,
    output logic [7:0]  o_latest_move_x,
    output logic [9:0]  o_latest_move_y,
    output logic        o_move_pending
);

    logic              r_ctrl;
    logic [1:0]        r_ctrl_type;
    logic              r_in_valid;
    logic              r_read_ok;
    logic              r_move_ack;
    logic [7:0]        r_b0, r_b1, r_b2, r_b3, r_b4, r_b5, r_b6, r_b7, r_b8;
    logic              r_out_valid;
    trdp_pkg::t_result r_out, n_out;
    logic              w_adv;
    trdp_pkg::t_sample w_sample;
    trdp_pkg::t_event  w_event;
    logic              w_active;
    logic [7:0]        w_cur_x;
    logic [9:0]        w_cur_y;
    logic [7:0]        w_lat_x;
    logic [9:0]        w_lat_y;
    logic              w_pend;

    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_type <= trdp_pkg::CTRL_NONE;
            r_ctrl      <= 1'b0;
        end else if (i_cfg_we) begin
            r_ctrl_type <= i_cfg_wdata;
            r_ctrl      <= 1'b1;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_read_ok  <= i_read_ok;
            r_move_ack <= i_move_acknowledged;
            r_b0 <= i_byte0;
            r_b1 <= i_byte1;
            r_b2 <= i_byte2;
            r_b3 <= i_byte3;
            r_b4 <= i_byte4;
            r_b5 <= i_byte5;
            r_b6 <= i_byte6;
            r_b7 <= i_byte7;
            r_b8 <= i_byte8;
        end
    end

    trdp_decoder #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_decoder (
        .i_ctrl    (r_ctrl_type),
        .i_read_ok (r_read_ok),
        .i_byte0   (r_b0),
        .i_byte1   (r_b1),
        .i_byte2   (r_b2),
        .i_byte3   (r_b3),
        .i_byte4   (r_b4),
        .i_byte5   (r_b5),
        .i_byte6   (r_b6),
        .i_byte7   (r_b7),
        .i_byte8   (r_b8),
        .o_sample  (w_sample)
    );

    trdp_tracker u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_adv),
        .i_move_ack (r_move_ack),
        .i_sample   (w_sample),
        .o_event    (w_event),
        .o_active   (w_active),
        .o_cur_x    (w_cur_x),
        .o_cur_y    (w_cur_y),
        .o_lat_x    (w_lat_x),
        .o_lat_y    (w_lat_y),
        .o_pend     (w_pend)
    );

    always_comb begin
        n_out.sample_valid  = w_sample.valid;
        n_out.ack_needed    = r_read_ok && (r_ctrl_type == trdp_pkg::CTRL_CSUM) && r_ctrl;
        n_out.event_res     = w_event;
        n_out.touching      = w_active;
        n_out.pos_x         = w_cur_x;
        n_out.pos_y         = w_cur_y;
        n_out.latest_move_x = w_lat_x;
        n_out.latest_move_y = w_lat_y;
        n_out.move_pending  = w_pend;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sample_valid  = r_out.sample_valid;
    assign o_ack_needed    = r_out.ack_needed;
    assign o_event_res     = r_out.event_res;
    assign o_touching      = r_out.touching;
    assign o_pos_x         = r_out.pos_x;
    assign o_pos_y         = r_out.pos_y;
    assign o_latest_move_x = r_out.latest_move_x;
    assign o_latest_move_y = r_out.latest_move_y;
    assign o_move_pending  = r_out.move_pending;

`ifndef NO_ASSERTIONS
    // Any phase event comes only from a sample that passed the checks.
    a_event_needs_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res != trdp_pkg::EV_NONE) |-> o_sample_valid)
        else $error("phase event reported for a rejected sample");

    // A down or move leaves contact on, with the latest position at the current one.
    a_down_move_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == trdp_pkg::EV_DOWN || o_event_res == trdp_pkg::EV_MOVE)
        |-> o_touching && o_latest_move_x == o_pos_x && o_latest_move_y == o_pos_y)
        else $error("down or move does not match the latest position");

    // A move event always leaves a move pending.
    a_move_pending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == trdp_pkg::EV_MOVE) |-> o_move_pending)
        else $error("move event without pending move");

    // An up event ends contact.
    a_up_release : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == trdp_pkg::EV_UP) |-> !o_touching)
        else $error("up event while still touching");

    // An item leaving the input register always shows up at the output.
    a_adv_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_valid)
        else $error("decoded item lost before the output register");
`endif

endmodule

FILE: bench/touch_report_decode_and_phase_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_report_decode_and_phase_unit_tb
// Self-checking bench for the touch report decoder and phase tracker.
// ----------------------------------------------------------------------------
// A queue of pending reports feeds a clocked driver. Each accepted report is
// run through a bench-side decoder and phase tracker, and the predicted
// result is queued. A clocked monitor compares each result with the oldest
// prediction, field by field. Both handshake sides idle at random. The
// receiver also holds off once for a long stretch so that the block stalls.
// The controller type is stepped through every value between phases, with
// directed corner reports first and then random gestures and noise.
// ----------------------------------------------------------------------------
module touch_report_decode_and_phase_unit_tb;

    localparam int PANEL_W = 180;
    localparam int PANEL_H = 640;

    typedef struct packed {
        logic            read_ok;
        logic            move_ack;
        logic [8:0][7:0] b;
    } t_report;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_wdata = 2'd0;
    logic       drv_valid = 1'b0;
    logic       rcv_ready = 1'b0;
    t_report    drv_rpt   = '0;

    logic       o_ready;
    logic       o_valid;
    logic       o_sample_valid;
    logic       o_ack_needed;
    logic [1:0] o_event_res;
    logic       o_touching;
    logic [7:0] o_pos_x;
    logic [9:0] o_pos_y;
    logic [7:0] o_latest_move_x;
    logic [9:0] o_latest_move_y;
    logic       o_move_pending;

    t_report           pending_rpts[$];
    trdp_pkg::t_result predicted[$];

    // Bench copy of the phase state and the format register.
    logic [1:0] fmt_sel = trdp_pkg::CTRL_NONE;
    logic       trk_active = 1'b0;
    logic [7:0] trk_cur_x = '0;
    logic [9:0] trk_cur_y = '0;
    logic [7:0] trk_lat_x = '0;
    logic [9:0] trk_lat_y = '0;
    logic       trk_pending = 1'b0;

    int errors       = 0;
    int accepted_cnt = 0;
    int results_seen = 0;
    int gen_cnt      = 0;
    int hold_left    = 0;
    bit hold_done    = 0;
    int n_valid = 0, n_down = 0, n_move = 0, n_up = 0, n_ack = 0;
    int fmt_cnt[4] = '{default: 0};

    always #10 clk = ~clk;

    touch_report_decode_and_phase_unit #(
        .PANEL_WIDTH (PANEL_W),
        .PANEL_HEIGHT(PANEL_H)
    ) i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_valid            (drv_valid),
        .o_ready            (o_ready),
        .i_read_ok          (drv_rpt.read_ok),
        .i_move_acknowledged(drv_rpt.move_ack),
        .i_byte0            (drv_rpt.b[0]),
        .i_byte1            (drv_rpt.b[1]),
        .i_byte2            (drv_rpt.b[2]),
        .i_byte3            (drv_rpt.b[3]),
        .i_byte4            (drv_rpt.b[4]),
        .i_byte5            (drv_rpt.b[5]),
        .i_byte6            (drv_rpt.b[6]),
        .i_byte7            (drv_rpt.b[7]),
        .i_byte8            (drv_rpt.b[8]),
        .o_valid            (o_valid),
        .i_ready            (rcv_ready),
        .o_sample_valid     (o_sample_valid),
        .o_ack_needed       (o_ack_needed),
        .o_event_res        (o_event_res),
        .o_touching         (o_touching),
        .o_pos_x            (o_pos_x),
        .o_pos_y            (o_pos_y),
        .o_latest_move_x    (o_latest_move_x),
        .o_latest_move_y    (o_latest_move_y),
        .o_move_pending     (o_move_pending)
    );

    // Decodes one report and advances the bench phase state.
    function automatic trdp_pkg::t_result track_report(input t_report r);
        logic              valid;
        logic              tch;
        int                sx;
        int                sy;
        logic [3:0]        fingers;
        logic [15:0]       sum;
        logic [7:0]        nx;
        logic [9:0]        ny;
        trdp_pkg::t_event  ev;
        trdp_pkg::t_result res;
        valid = 1'b0;
        tch   = 1'b0;
        sx    = 0;
        sy    = 0;
        ev    = trdp_pkg::EV_NONE;
        if (r.move_ack) trk_pending = 1'b0;
        if (r.read_ok) begin
            if (fmt_sel == trdp_pkg::CTRL_CSUM) begin
                fingers = r.b[3][3:0];
                sum = trdp_pkg::CSUM_SEED + r.b[4] + r.b[5] + r.b[6] + r.b[7] + r.b[8];
                if (r.b[2] == trdp_pkg::HDR_BYTE && fingers <= 4'd1) begin
                    if (fingers == 4'd0 || r.b[8][7:4] == 4'd0) begin
                        valid = 1'b1;
                    end else if (sum == {r.b[1], r.b[0]}) begin
                        tch = 1'b1;
                        sx  = int'({r.b[7][3:0], r.b[4]});
                        sy  = int'({r.b[7][7:4], r.b[5]});
                    end
                end
            end else if (fmt_sel == trdp_pkg::CTRL_EVENT) begin
                if (r.b[1] != trdp_pkg::ONE_FINGER || r.b[2][7:4] != trdp_pkg::EVT_TOUCH) begin
                    valid = 1'b1;
                end else begin
                    tch = 1'b1;
                    sx  = int'({r.b[4][3:0], r.b[5]});
                    sy  = PANEL_H - int'({r.b[2][3:0], r.b[3]});
                end
            end
            if (tch) valid = (sx >= 0 && sx < PANEL_W && sy >= 0 && sy < PANEL_H);
        end
        if (valid) begin
            nx = tch ? sx[7:0] : trk_cur_x;
            ny = tch ? sy[9:0] : trk_cur_y;
            if (tch && !trk_active) begin
                trk_lat_x = nx;
                trk_lat_y = ny;
                ev = trdp_pkg::EV_DOWN;
            end else if (tch && (nx != trk_cur_x || ny != trk_cur_y)) begin
                // Moves coalesce: latest follows, but only the first one is signalled.
                trk_lat_x = nx;
                trk_lat_y = ny;
                if (!trk_pending) begin
                    trk_pending = 1'b1;
                    ev = trdp_pkg::EV_MOVE;
                end
            end else if (!tch && trk_active) begin
                ev = trdp_pkg::EV_UP;
            end
            trk_cur_x  = nx;
            trk_cur_y  = ny;
            trk_active = tch;
        end
        res.sample_valid  = valid;
        res.ack_needed    = r.read_ok && fmt_sel == trdp_pkg::CTRL_CSUM;
        res.event_res     = ev;
        res.touching      = trk_active;
        res.pos_x         = trk_cur_x;
        res.pos_y         = trk_cur_y;
        res.latest_move_x = trk_lat_x;
        res.latest_move_y = trk_lat_y;
        res.move_pending  = trk_pending;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Well-formed touch in the checksum format.
    function automatic t_report csum_touch(input int x, input int y);
        t_report     r;
        logic [11:0] xr;
        logic [11:0] yr;
        logic [15:0] sum;
        xr = x[11:0];
        yr = y[11:0];
        r = '0;
        r.read_ok = 1'b1;
        r.b[2] = trdp_pkg::HDR_BYTE;
        r.b[3] = {4'($urandom_range(0, 15)), 4'd1};
        r.b[4] = xr[7:0];
        r.b[5] = yr[7:0];
        r.b[6] = 8'($urandom);
        r.b[7] = {yr[11:8], xr[11:8]};
        r.b[8] = {4'($urandom_range(1, 15)), 4'($urandom_range(0, 15))};
        sum = trdp_pkg::CSUM_SEED + r.b[4] + r.b[5] + r.b[6] + r.b[7] + r.b[8];
        r.b[0] = sum[7:0];
        r.b[1] = sum[15:8];
        return r;
    endfunction

    // Well-formed touch in the event format; Y is given in panel terms.
    function automatic t_report event_touch(input int x, input int y);
        t_report     r;
        logic [11:0] xr;
        logic [11:0] raw;
        xr  = x[11:0];
        raw = 12'(PANEL_H - y);
        r = '0;
        r.read_ok = 1'b1;
        r.b[0] = 8'($urandom);
        r.b[1] = trdp_pkg::ONE_FINGER;
        r.b[2] = {trdp_pkg::EVT_TOUCH, raw[11:8]};
        r.b[3] = raw[7:0];
        r.b[4] = {4'($urandom_range(0, 15)), xr[11:8]};
        r.b[5] = xr[7:0];
        r.b[6] = 8'($urandom);
        r.b[7] = 8'($urandom);
        r.b[8] = 8'($urandom);
        return r;
    endfunction

    // Random bytes with a mostly successful read.
    function automatic t_report noise_rpt();
        t_report r;
        r = '0;
        for (int i = 0; i < 9; i++) r.b[i] = 8'($urandom);
        r.read_ok = ($urandom_range(0, 99) < 85);
        return r;
    endfunction

    function automatic t_report touch_rpt(input logic [1:0] fmt, input int x, input int y);
        return (fmt == trdp_pkg::CTRL_EVENT) ? event_touch(x, y) : csum_touch(x, y);
    endfunction

    function automatic t_report release_rpt(input logic [1:0] fmt);
        t_report r;
        if (fmt == trdp_pkg::CTRL_EVENT) begin
            r = event_touch($urandom_range(0, PANEL_W - 1), $urandom_range(0, PANEL_H - 1));
            if ($urandom_range(0, 1)) begin
                r.b[1] = 8'($urandom);
                if (r.b[1] == trdp_pkg::ONE_FINGER) r.b[1] = 8'd0;
            end else begin
                r.b[2][7:4] = 4'($urandom_range(0, 15));
                if (r.b[2][7:4] == trdp_pkg::EVT_TOUCH) r.b[2][7:4] = 4'h0;
            end
        end else begin
            r = csum_touch($urandom_range(0, PANEL_W - 1), $urandom_range(0, PANEL_H - 1));
            if ($urandom_range(0, 1)) r.b[3][3:0] = 4'd0;
            else r.b[8][7:4] = 4'd0;
        end
        return r;
    endfunction

    function automatic int rand_x();
        if ($urandom_range(0, 99) < 90) return $urandom_range(0, PANEL_W - 1);
        return $urandom_range(PANEL_W, 4095);
    endfunction

    // Event-format Y below zero comes from raw values past the panel, Y at the height from a raw zero.
    function automatic int rand_y(input logic [1:0] fmt);
        if ($urandom_range(0, 99) < 90) return $urandom_range(0, PANEL_H - 1);
        if (fmt != trdp_pkg::CTRL_EVENT) return $urandom_range(PANEL_H, 4095);
        if ($urandom_range(0, 1)) return PANEL_H;
        return PANEL_H - int'($urandom_range(PANEL_H + 1, 4095));
    endfunction

    task automatic push_rand(input t_report r);
        int pick;
        pick = $urandom_range(0, 99);
        r.move_ack = ($urandom_range(0, 99) < 30);
        if (pick < 8) r.b[$urandom_range(0, 8)] ^= 8'($urandom_range(1, 255));
        else if (pick < 12) r.read_ok = 1'b0;
        pending_rpts.push_back(r);
        gen_cnt++;
    endtask

    // One finger-down, a few moves or repeats, then usually a release.
    task automatic push_gesture(input logic [1:0] fmt);
        int x;
        int y;
        int n;
        int ylo;
        int yhi;
        ylo = (fmt == trdp_pkg::CTRL_EVENT) ? PANEL_H - 4095 : 0;
        yhi = (fmt == trdp_pkg::CTRL_EVENT) ? PANEL_H : 4095;
        x = rand_x();
        y = rand_y(fmt);
        n = $urandom_range(0, 8);
        push_rand(touch_rpt(fmt, x, y));
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: ;
                3: begin
                    x = rand_x();
                    y = rand_y(fmt);
                end
                default: begin
                    x = clamp(x + int'($urandom_range(0, 6)) - 3, 0, 4095);
                    y = clamp(y + int'($urandom_range(0, 6)) - 3, ylo, yhi);
                end
            endcase
            push_rand(touch_rpt(fmt, x, y));
        end
        if ($urandom_range(0, 99) < 85) push_rand(release_rpt(fmt));
    endtask

    task automatic run_random(input int n);
        int         target;
        logic [1:0] fmt;
        t_report    r;
        target = gen_cnt + n;
        while (gen_cnt < target) begin
            if (fmt_sel == trdp_pkg::CTRL_CSUM || fmt_sel == trdp_pkg::CTRL_EVENT) begin
                fmt = fmt_sel;
            end else begin
                fmt = $urandom_range(0, 1) ? trdp_pkg::CTRL_CSUM : trdp_pkg::CTRL_EVENT;
            end
            if ($urandom_range(0, 99) < 75) begin
                push_gesture(fmt);
            end else begin
                r = noise_rpt();
                if ($urandom_range(0, 1)) r.b[2] = trdp_pkg::HDR_BYTE;
                push_rand(r);
            end
        end
    endtask

    task automatic settle();
        while (pending_rpts.size() != 0 || drv_valid || predicted.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_ctrl(input logic [1:0] v);
        settle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        fmt_sel   = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Driver: offers the next pending report, predicting each one on acceptance.
    always @(posedge clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && o_ready) begin
                predicted.push_back(track_report(drv_rpt));
                fmt_cnt[fmt_sel]++;
                accepted_cnt++;
            end
            if (!drv_valid || o_ready) begin
                if (pending_rpts.size() != 0 &&
                    ((accepted_cnt >= 600 && accepted_cnt < 720) ||
                     $urandom_range(0, 99) >= 29)) begin
                    drv_rpt   <= pending_rpts.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result item against the oldest prediction.
    always @(posedge clk) begin : monitor
        trdp_pkg::t_result want;
        if (!rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            if (o_valid && rcv_ready) begin
                if (predicted.size() == 0) begin
                    $display("%0t: result item arrived with nothing predicted", $time);
                    errors++;
                end else begin
                    want = predicted.pop_front();
                    check_field("sample_valid", want.sample_valid, o_sample_valid);
                    check_field("ack_needed", want.ack_needed, o_ack_needed);
                    check_field("event_res", want.event_res, o_event_res);
                    check_field("touching", want.touching, o_touching);
                    check_field("pos_x", want.pos_x, o_pos_x);
                    check_field("pos_y", want.pos_y, o_pos_y);
                    check_field("latest_move_x", want.latest_move_x, o_latest_move_x);
                    check_field("latest_move_y", want.latest_move_y, o_latest_move_y);
                    check_field("move_pending", want.move_pending, o_move_pending);
                    n_valid += want.sample_valid;
                    n_ack   += want.ack_needed;
                    n_down  += (want.event_res == trdp_pkg::EV_DOWN);
                    n_move  += (want.event_res == trdp_pkg::EV_MOVE);
                    n_up    += (want.event_res == trdp_pkg::EV_UP);
                end
                results_seen++;
            end
            // One long hold-off so the input side backs up and stalls.
            if (!hold_done && results_seen >= 400) begin
                hold_left = 120;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rcv_ready <= 1'b0;
            end else begin
                rcv_ready <= (results_seen >= 600 && results_seen < 720) ||
                             ($urandom_range(0, 99) >= 29);
            end
        end
    end

    initial begin
        t_report r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No format selected: everything is rejected.
        write_ctrl(trdp_pkg::CTRL_NONE);
        pending_rpts.push_back(csum_touch(20, 30));
        pending_rpts.push_back(noise_rpt());

        // Checksum format corners.
        write_ctrl(trdp_pkg::CTRL_CSUM);
        pending_rpts.push_back(csum_touch(0, 0));
        pending_rpts.push_back(csum_touch(PANEL_W - 1, PANEL_H - 1));
        pending_rpts.push_back(csum_touch(PANEL_W - 1, PANEL_H - 1));
        pending_rpts.push_back(csum_touch(10, 20));
        r = csum_touch(11, 20);
        r.move_ack = 1'b1;
        pending_rpts.push_back(r);
        r = csum_touch(50, 60);
        r.b[0] ^= 8'h01;
        pending_rpts.push_back(r);
        r = csum_touch(50, 60);
        r.b[2] = 8'hfe;
        pending_rpts.push_back(r);
        r = csum_touch(50, 60);
        r.b[3][3:0] = 4'd2;
        pending_rpts.push_back(r);
        r = csum_touch(50, 60);
        r.read_ok = 1'b0;
        pending_rpts.push_back(r);
        pending_rpts.push_back(csum_touch(PANEL_W, 5));
        pending_rpts.push_back(csum_touch(5, PANEL_H));
        r = csum_touch(50, 60);
        r.b[3][3:0] = 4'd0;
        pending_rpts.push_back(r);
        r = csum_touch(50, 60);
        r.b[8][7:4] = 4'd0;
        pending_rpts.push_back(r);

        // Event format corners, Y mirrored against the height.
        write_ctrl(trdp_pkg::CTRL_EVENT);
        pending_rpts.push_back(event_touch(PANEL_W - 1, PANEL_H - 1));
        r = event_touch(0, 0);
        r.move_ack = 1'b1;
        pending_rpts.push_back(r);
        pending_rpts.push_back(event_touch(5, PANEL_H));
        pending_rpts.push_back(event_touch(PANEL_W, 5));
        r = event_touch(5, 5);
        r.b[1] = 8'd0;
        pending_rpts.push_back(r);
        r = event_touch(5, 5);
        r.b[2][7:4] = 4'h4;
        pending_rpts.push_back(r);
        r = event_touch(5, 5);
        r.b[1] = 8'd2;
        pending_rpts.push_back(r);

        // Unused format code.
        write_ctrl(trdp_pkg::CTRL_RSVD);
        pending_rpts.push_back(event_touch(30, 40));
        pending_rpts.push_back(csum_touch(30, 40));

        write_ctrl(trdp_pkg::CTRL_CSUM);
        run_random(150);
        write_ctrl(trdp_pkg::CTRL_EVENT);
        run_random(150);
        write_ctrl(trdp_pkg::CTRL_CSUM);
        run_random(150);
        write_ctrl(trdp_pkg::CTRL_NONE);
        run_random(40);
        write_ctrl(trdp_pkg::CTRL_EVENT);
        run_random(150);
        write_ctrl(trdp_pkg::CTRL_RSVD);
        run_random(40);
        write_ctrl(trdp_pkg::CTRL_CSUM);
        run_random(110);
        write_ctrl(trdp_pkg::CTRL_EVENT);
        run_random(110);

        settle();
        repeat (10) @(posedge clk);
        $display("Covered %0d reports (types 0/1/2/3: %0d/%0d/%0d/%0d), %0d valid samples.",
                 accepted_cnt, fmt_cnt[0], fmt_cnt[1], fmt_cnt[2], fmt_cnt[3], n_valid);
        $display("Phases seen: %0d down, %0d move, %0d up; %0d acknowledge requests.",
                 n_down, n_move, n_up, n_ack);
        if (errors == 0 && predicted.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("Timeout with %0d results still outstanding", predicted.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
